// File: rtl/core/sssp_pkg.sv
// ----------------------------------------------------------------------------
// Seek-scan station picker package
// Shared types, sizes and codes for the seek-scan station picker block.
// ----------------------------------------------------------------------------
package sssp_pkg;

    // The size of the station table. IDX_W and CNT_W below follow from it.
    localparam int MAX_STATIONS = 64;
    localparam int IDX_W        = $clog2(MAX_STATIONS);
    localparam int CNT_W        = $clog2(MAX_STATIONS + 1);

    localparam int FREQ_W  = 31;
    localparam int SNR_W   = 16;
    localparam int SUM_W   = 32;
    localparam int HITS_W  = 16;
    localparam int THR_W   = 8;
    localparam int PROD_W  = SUM_W + HITS_W + 1;

    localparam logic [HITS_W-1:0] HITS_MAX  = '1;
    localparam logic [THR_W-1:0]  THR_RESET = 8'd10;

    // Command codes carried in the cmd field.
    localparam logic [1:0] CMD_MEAS  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [FREQ_W-1:0]        tuned_frequency;
        logic signed [SNR_W-1:0]  snr_db;
    } in_item_t;

    typedef struct packed {
        logic                     station_found;
        logic [FREQ_W-1:0]        station_frequency;
        logic                     scan_active;
        logic                     sample_taken;
        logic                     table_overflow;
    } res_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic signed [SUM_W-1:0]  sum;
        logic [HITS_W-1:0]        hits;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_LO,
        ST_RD_HI,
        ST_CAP_HI,
        ST_MUL_A,
        ST_MUL_B,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic rd_hi;
        logic cap_a;
        logic cap_b;
        logic mul_a;
        logic mul_b;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pick_needed;
    } dp_status_t;

endpackage

// File: rtl/core/sssp_ctrl.sv
// ----------------------------------------------------------------------------
// Seek-scan station picker controller
// Sequences one request through the datapath and raises the result strobe.
// ----------------------------------------------------------------------------
module sssp_ctrl
    import sssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.pick_needed ? ST_RD_LO : ST_IDLE;
            end
            ST_RD_LO:  state_next = ST_RD_HI;
            ST_RD_HI:  state_next = ST_CAP_HI;
            ST_CAP_HI: state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        done_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EXEC:
            begin
                cmd.exec  = 1'b1;
                done_next = !status.pick_needed;
            end
            ST_RD_LO:  cmd.rd_hi = 1'b0;
            ST_RD_HI:
            begin
                cmd.rd_hi = 1'b1;
                cmd.cap_a = 1'b1;
            end
            ST_CAP_HI: cmd.cap_b = 1'b1;
            ST_MUL_A:  cmd.mul_a = 1'b1;
            ST_MUL_B:  cmd.mul_b = 1'b1;
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
            end
            default:   cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/core/sssp_dp.sv
// ----------------------------------------------------------------------------
// Seek-scan station picker datapath
// Holds the threshold, scan flags, station table and the pick arithmetic.
// ----------------------------------------------------------------------------
module sssp_dp
    import sssp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         item,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    output res_t             result
);

    // Station table memory and its registered read port.
    entry_t mem [MAX_STATIONS];
    entry_t mem_q;

    in_item_t                  item_reg;
    logic signed [THR_W-1:0]   thr_reg;
    logic                      armed_reg;
    logic                      armed_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    entry_t                    tail_reg;
    entry_t                    a_reg;
    entry_t                    b_reg;
    logic signed [PROD_W-1:0]  prod_a_reg;
    logic signed [PROD_W-1:0]  prod_b_reg;
    res_t                      res_reg;

    logic                      is_meas;
    logic                      taken;
    logic                      above;
    logic                      repeat_hit;
    logic                      full;
    logic                      hit;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    entry_t                    wr_data;
    logic [IDX_W-1:0]          hi_idx;
    logic [IDX_W-1:0]          lo_idx;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [SUM_W-1:0]   snr_ext;
    logic                      choose_a;

    assign is_meas    = (item_reg.cmd == CMD_MEAS);
    assign taken      = is_meas && armed_reg;
    assign above      = item_reg.snr_db > $signed({thr_reg, 8'h00});
    assign repeat_hit = (count_reg != '0) && (tail_reg.freq == item_reg.tuned_frequency);
    assign full       = (count_reg == CNT_W'(MAX_STATIONS));
    assign hit        = taken && above;
    assign snr_ext    = SUM_W'(item_reg.snr_db);

    assign status.pick_needed = taken && !above && (count_reg != '0);

    // A repeat of the last frequency updates that entry in place unless its hit
    // count is saturated; a new frequency is appended while there is room.
    always_comb
    begin
        if (repeat_hit)
        begin
            wr_en        = cmd.exec && hit && (tail_reg.hits != HITS_MAX);
            wr_addr      = IDX_W'(count_reg - 1'b1);
            wr_data.freq = tail_reg.freq;
            wr_data.sum  = tail_reg.sum + snr_ext;
            wr_data.hits = tail_reg.hits + 1'b1;
        end
        else
        begin
            wr_en        = cmd.exec && hit && !full;
            wr_addr      = IDX_W'(count_reg);
            wr_data.freq = item_reg.tuned_frequency;
            wr_data.sum  = snr_ext;
            wr_data.hits = HITS_W'(1);
        end
    end

    always_comb
    begin
        armed_next = armed_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.exec)
        begin
            case (item_reg.cmd)
                CMD_START: armed_next = 1'b1;
                CMD_STOP:  armed_next = 1'b0;
                default:   armed_next = armed_reg;
            endcase
            if (wr_en && !repeat_hit)
            begin
                count_next = count_reg + 1'b1;
            end
            if (hit && !repeat_hit && full)
            begin
                ovf_next = 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            armed_next = 1'b0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // The upper middle entry, and the one below it for an even count.
    assign hi_idx   = IDX_W'(count_reg >> 1);
    assign lo_idx   = hi_idx - 1'b1;
    assign rd_addr  = cmd.rd_hi ? hi_idx : lo_idx;
    assign choose_a = !count_reg[0] && (prod_a_reg > prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            armed_reg <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            armed_reg <= armed_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (wr_en)
        begin
            tail_reg <= wr_data;
        end
        if (cmd.cap_a)
        begin
            a_reg <= mem_q;
        end
        if (cmd.cap_b)
        begin
            b_reg <= mem_q;
        end
        if (cmd.mul_a)
        begin
            prod_a_reg <= PROD_W'(a_reg.sum * $signed({1'b0, b_reg.hits}));
        end
        if (cmd.mul_b)
        begin
            prod_b_reg <= PROD_W'(b_reg.sum * $signed({1'b0, a_reg.hits}));
        end
        if (cmd.exec && !status.pick_needed)
        begin
            res_reg.station_found     <= 1'b0;
            res_reg.station_frequency <= '0;
            res_reg.scan_active       <= armed_next;
            res_reg.sample_taken      <= taken;
            res_reg.table_overflow    <= ovf_next;
        end
        else if (cmd.finish)
        begin
            res_reg.station_found     <= 1'b1;
            res_reg.station_frequency <= choose_a ? a_reg.freq : b_reg.freq;
            res_reg.scan_active       <= 1'b0;
            res_reg.sample_taken      <= 1'b1;
            res_reg.table_overflow    <= ovf_reg;
        end
    end

    assign result = res_reg;

endmodule

// File: rtl/core/seek_scan_station_picker_top.sv
// ----------------------------------------------------------------------------
// Seek-scan station picker
// Arms on a start command, gathers stations above the SNR threshold and
// reports the middle station when the scan ends.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. An ordinary request
// goes through the execute state to its result; a measurement that ends the
// scan also passes the RD_LO, RD_HI, CAP_HI, MUL_A, MUL_B and FINISH states,
// because the two middle table entries are read one after the other through
// the single read port of the entry memory and their two cross products are
// formed on separate cycles. Every request yields exactly one result, shown
// for one cycle with done high; the receiver cannot hold it off, so it must
// sample result whenever done is high. A new request may be presented in the
// same cycle as the previous result. The threshold register may be written
// whenever cfg_ready is high, which is whenever busy is low. The entry memory
// needs no clearing after reset: only entries below the current fill count
// are ever used in a result.
module seek_scan_station_picker_top
    import sssp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    output logic             done,
    output res_t             result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // The controller sequences each request through the datapath.
    sssp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (ctrl_cmd),
        .busy   (busy),
        .done   (done)
    );

    // The threshold is only written while no request is in flight.
    assign cfg_ready = !busy;

    sssp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (ctrl_cmd),
        .status   (dp_status),
        .result   (result)
    );

    // A result is only shown once the controller has gone back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in flight");

    // An accepted request always keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A pick always consumes a sample and disarms the scan.
    a_pick_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.station_found) |-> (result.sample_taken && !result.scan_active))
        else $error("pick reported with inconsistent flags");

endmodule
